@@ hdl/rikc_pkg.sv @@
// Package for the RTC, interrupt and keyboard controller: item types, state
// record, register codes and small helper functions. No dependencies.
package rikc_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] PORT_COM  = 8'hB0;
  localparam logic [7:0] PORT_INT  = 8'hB1;
  localparam logic [7:0] PORT_KBD  = 8'hB2;
  localparam logic [7:0] PORT_TACK = 8'hB4;
  localparam logic [7:0] PORT_TMK  = 8'hB5;
  localparam logic [7:0] PORT_ACK  = 8'hB6;
  localparam logic [7:0] PORT_TIM0 = 8'hD0;
  localparam logic [7:0] PORT_TIM1 = 8'hD1;
  localparam logic [7:0] PORT_TIM2 = 8'hD2;
  localparam logic [7:0] PORT_TIM3 = 8'hD3;
  localparam logic [7:0] PORT_TIM4 = 8'hD4;

  localparam logic [7:0] MS5_WRAP  = 8'd200;
  localparam logic [5:0] SEC_WRAP  = 6'd60;
  localparam logic [7:0] INT_MASK  = 8'hFC;
  localparam logic [7:0] ACK_MASK  = 8'h6C;
  localparam logic [7:0] BUS_IDLE  = 8'hFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  port;
    logic [7:0]  addr_high;
    logic [7:0]  wdata;
    logic [63:0] key_matrix;
  } in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       speaker;
    logic       snoozing;
  } out_t;

  typedef struct packed {
    logic [7:0] int_enable;
    logic [7:0] int_status;
    logic [2:0] timer_status;
    logic [2:0] timer_mask;
    logic [7:0] command_reg;
    logic [7:0] count_ms5;
    logic [5:0] count_sec;
    logic [7:0] count_min_lo;
    logic [7:0] count_min_mid;
    logic [4:0] count_min_hi;
    logic       snooze_flag;
    logic       speaker_level;
  } state_t;

  // x / 10 by reciprocal (exact for all 8-bit x), then check the remainder
  function automatic logic is_mult10(input logic [7:0] x);
    logic [15:0] prod;
    logic [4:0]  quot;
    logic [7:0]  back;
    prod = {8'd0, x} * 16'd205;
    quot = prod[15:11];
    back = {3'd0, quot} * 8'd10;
    return back == x;
  endfunction

  function automatic logic irq_of(input state_t s);
    return s.int_enable[0] &&
           (((s.int_enable & s.int_status & INT_MASK) != 8'd0) ||
            (s.int_enable[2] && s.int_status[1]));
  endfunction

endpackage

@@ hdl/rikc_exec.sv @@
// Next-state and result logic for one item of the RTC, interrupt and
// keyboard controller. Depends on rikc_pkg.
module rikc_exec (
  input  rikc_pkg::state_t st,
  input  rikc_pkg::in_t    item,
  output rikc_pkg::state_t st_nxt,
  output rikc_pkg::out_t   res
);

  logic [7:0] all_and;
  logic [7:0] sel_and;
  logic [7:0] ms5_inc;
  logic [5:0] sec_inc;
  logic [7:0] rd;
  logic       raised;
  logic       upd;

  assign ms5_inc = st.count_ms5 + 8'd1;
  assign sec_inc = st.count_sec + 6'd1;

  always_comb begin
    all_and = 8'hFF;
    sel_and = 8'hFF;
    for (int n = 0; n < 8; n++) begin
      all_and = all_and & item.key_matrix[8*n +: 8];
      if (!item.addr_high[n]) begin
        sel_and = sel_and & item.key_matrix[8*n +: 8];
      end
    end
  end

  always_comb begin
    st_nxt = st;
    rd     = rikc_pkg::BUS_IDLE;
    raised = 1'b0;
    upd    = 1'b0;
    unique case (item.action)
      rikc_pkg::ACT_TICK: begin
        if (st.snooze_flag && all_and != 8'hFF) begin
          st_nxt.snooze_flag   = 1'b0;
          st_nxt.int_status[2] = 1'b1;
        end
        if (!st.command_reg[4]) begin
          st_nxt.count_ms5 = ms5_inc;
          if (rikc_pkg::is_mult10(ms5_inc)) begin
            st_nxt.timer_status[0] = 1'b1;
            raised = 1'b1;
          end
          if (ms5_inc == rikc_pkg::MS5_WRAP) begin
            st_nxt.count_ms5       = 8'd0;
            st_nxt.timer_status[1] = 1'b1;
            raised                 = 1'b1;
            st_nxt.count_sec       = sec_inc;
            if (sec_inc == rikc_pkg::SEC_WRAP) begin
              st_nxt.timer_status[2] = 1'b1;
              st_nxt.count_sec       = 6'd0;
              st_nxt.count_min_lo    = st.count_min_lo + 8'd1;
              if (st.count_min_lo == 8'hFF) begin
                st_nxt.count_min_mid = st.count_min_mid + 8'd1;
                if (st.count_min_mid == 8'hFF) begin
                  st_nxt.count_min_hi = st.count_min_hi + 5'd1;
                end
              end
            end
          end
        end
        upd = raised;
      end
      rikc_pkg::ACT_WRITE: begin
        unique case (item.port)
          rikc_pkg::PORT_COM: begin
            st_nxt.command_reg = item.wdata;
            if (item.wdata[4]) begin
              st_nxt.count_ms5     = 8'd0;
              st_nxt.count_sec     = 6'd0;
              st_nxt.count_min_lo  = 8'd0;
              st_nxt.count_min_mid = 8'd0;
              st_nxt.count_min_hi  = 5'd0;
            end
            if (!item.wdata[7] && (st.command_reg[6] ^ item.wdata[6])) begin
              st_nxt.speaker_level = item.wdata[6];
            end
          end
          rikc_pkg::PORT_INT: begin
            st_nxt.int_enable = item.wdata;
            upd = 1'b1;
          end
          rikc_pkg::PORT_TACK: begin
            st_nxt.timer_status = st.timer_status & ~item.wdata[2:0];
            upd = 1'b1;
          end
          rikc_pkg::PORT_TMK: begin
            st_nxt.timer_mask = item.wdata[2:0];
            upd = 1'b1;
          end
          rikc_pkg::PORT_ACK: begin
            st_nxt.int_status = st.int_status & ~(item.wdata & rikc_pkg::ACK_MASK);
            upd = 1'b1;
          end
          default: begin
          end
        endcase
      end
      rikc_pkg::ACT_READ: begin
        unique case (item.port)
          rikc_pkg::PORT_INT: begin
            st_nxt.int_status[1] = 1'b0;
            rd = {st.int_status[7:2], 1'b0, st.int_status[0]};
          end
          rikc_pkg::PORT_KBD: begin
            if (st.int_enable[7]) begin
              st_nxt.snooze_flag = 1'b1;
            end
            rd = sel_and;
          end
          rikc_pkg::PORT_TMK: begin
            rd = {5'd0, st.timer_status};
            st_nxt.timer_status = 3'd0;
          end
          rikc_pkg::PORT_TIM0: rd = st.count_ms5;
          rikc_pkg::PORT_TIM1: rd = {2'd0, st.count_sec};
          rikc_pkg::PORT_TIM2: rd = st.count_min_lo;
          rikc_pkg::PORT_TIM3: rd = st.count_min_mid;
          rikc_pkg::PORT_TIM4: rd = {3'd0, st.count_min_hi};
          default: rd = rikc_pkg::BUS_IDLE;
        endcase
      end
      default: begin
      end
    endcase
    if (upd) begin
      st_nxt.int_status[1] = st_nxt.int_enable[1] && (st_nxt.timer_status != 3'd0);
    end
  end

  assign res.rdata    = rd;
  assign res.irq      = rikc_pkg::irq_of(st_nxt);
  assign res.speaker  = st_nxt.speaker_level;
  assign res.snoozing = st_nxt.snooze_flag;

endmodule

@@ hdl/rtc_interrupt_keyboard_controller.sv @@
// Top level of the RTC, interrupt and keyboard controller: handshakes,
// input and result registers, controller state. Depends on rikc_pkg, rikc_exec.
//
// Takes one item per clock: a 5 ms tick, a register write or a register read.
// Each item lands in an input register, then one pass of logic (the counter
// chain increment and the interrupt/status update in rikc_exec) updates the
// controller state and loads the result register; items flow at one per
// cycle as long as results are taken. A waiting result holds the state; the
// input register still takes one more item. Every item gives exactly one
// result; rdata is 0xff for ticks, writes and unmapped reads.
module rtc_interrupt_keyboard_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rikc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rikc_pkg::out_t out_data
);

  logic             s1_valid_r;
  rikc_pkg::in_t    s1_r;
  logic             out_valid_r;
  rikc_pkg::out_t   out_r;
  rikc_pkg::state_t st_r;
  rikc_pkg::state_t st_nxt;
  rikc_pkg::out_t   res;
  logic             s1_adv;
  logic             s1_fire;

  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  rikc_exec u_exec (
    .st     (st_r),
    .item   (s1_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.irq == rikc_pkg::irq_of(st_r)) &&
                    (out_r.snoozing == st_r.snooze_flag) &&
                    (out_r.speaker == st_r.speaker_level))
    else $error("result flags disagree with controller state");

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.count_ms5 < rikc_pkg::MS5_WRAP) && (st_r.count_sec < rikc_pkg::SEC_WRAP))
    else $error("counter chain out of range");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(st_r))
    else $error("state changed while result stalled");

  a_input_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(s1_r))
    else $error("input register lost a stalled item");

endmodule
